@@ src/dta_pkg.sv @@
// Shared types and codes for the descriptor table allocator.
package dta_pkg;

  localparam logic [2:0] CMD_ALLOC = 3'd0;
  localparam logic [2:0] CMD_FREE  = 3'd1;
  localparam logic [2:0] CMD_DUP   = 3'd2;
  localparam logic [2:0] CMD_GET   = 3'd3;
  localparam logic [2:0] CMD_FGET  = 3'd4;
  localparam logic [2:0] CMD_FSET  = 3'd5;
  localparam logic [2:0] CMD_EXEC  = 3'd6;
  localparam logic [2:0] CMD_EXIT  = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BADF  = 2'd1;
  localparam logic [1:0] ST_INVAL = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  localparam int SLOT_W   = 7;
  localparam int HANDLE_W = 32;

  typedef struct packed {
    logic [2:0]          cmd;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic                cloexec;
    logic                is_dir;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [SLOT_W-1:0]   slot_out;
    logic [HANDLE_W-1:0] handle_out;
    logic                handle_present;
    logic                flag_out;
    logic                last;
  } rsp_t;

  typedef struct packed {
    logic valid;
    logic cloexec;
    logic is_dir;
  } mark_t;

endpackage

@@ src/dta_chan_if.sv @@
// Valid/ready channel carrying one payload per transaction.
interface dta_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ src/descriptor_table_allocator_top.sv @@
// Descriptor table allocator: ring of entry cells with a command sequencer.
//
// The table is a ring of SLOTS cells that rotates one entry per cycle past a
// head position, where the sequencer reads and rewrites the entry; it rotates
// only while a command runs and holds while a sweep stalls. A single-entry
// command rotates until its slot reaches the head; the result goes through the
// pending register into the output register. Alloc runs from the minimum slot
// upwards until a free entry is found or the last slot reports full. The exec
// and exit sweeps ignore the slot field, align to slot 0 and make one full
// turn, stalling while the result side holds a closed-entry result. A slot out
// of range skips the ring and goes straight to the flush with an error status.
// A new command is taken only once the previous one has delivered its final
// result into the output register, at the earliest in the cycle after.
module descriptor_table_allocator_top #(
  parameter int SLOTS       = 64,
  parameter int HANDLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  dta_chan_if.sink    req,
  dta_chan_if.source  rsp
);

  localparam int PW = $clog2(SLOTS);
  localparam int CW = (PW > dta_pkg::SLOT_W ? PW : dta_pkg::SLOT_W) + 1;
  localparam logic [PW-1:0] POS_LAST = PW'(SLOTS - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  dta_pkg::mark_t         mark_q [SLOTS];
  logic [HANDLE_BITS-1:0] hnd_q  [SLOTS];
  dta_pkg::mark_t         tail_m;
  logic [HANDLE_BITS-1:0] tail_h;

  logic [1:0]             state, state_next;
  logic [PW-1:0]          pos;
  logic                   armed, armed_next;
  logic [2:0]             cmd_r;
  logic [PW-1:0]          start;
  logic                   ce_r, dir_r;
  logic [HANDLE_BITS-1:0] hin_r;
  dta_pkg::rsp_t          pend, pend_next;
  logic                   pend_v, pend_v_next;
  logic                   ov;
  dta_pkg::rsp_t          o;

  logic                   acc, push, push_ok, hit, is_sweep, close, stall, rot, in_range;
  dta_pkg::rsp_t          push_data;
  dta_pkg::mark_t         head_m;
  logic [HANDLE_BITS-1:0] head_h;

  genvar k;
  generate
    for (k = 0; k < SLOTS; k++) begin : g_ring
      if (k == SLOTS - 1) begin : g_tail
        dta_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
          .clk(clk), .rst(rst), .shift(rot),
          .mark_in(tail_m), .handle_in(tail_h),
          .mark(mark_q[k]), .handle(hnd_q[k])
        );
      end else begin : g_mid
        dta_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
          .clk(clk), .rst(rst), .shift(rot),
          .mark_in(mark_q[k+1]), .handle_in(hnd_q[k+1]),
          .mark(mark_q[k]), .handle(hnd_q[k])
        );
      end
    end
  endgenerate

  assign head_m    = mark_q[0];
  assign head_h    = hnd_q[0];
  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign push_ok   = !ov || rsp.ready;
  assign in_range  = CW'(req.payload.slot) < CW'(SLOTS);
  assign hit       = armed || (pos == start);
  assign is_sweep  = (cmd_r == dta_pkg::CMD_EXEC) || (cmd_r == dta_pkg::CMD_EXIT);
  assign close     = head_m.valid &&
                     ((cmd_r == dta_pkg::CMD_EXIT) || head_m.cloexec || head_m.is_dir);
  assign stall     = hit && is_sweep && close && pend_v && !push_ok;
  assign rot       = (state == S_RUN) && !stall;
  assign rsp.valid   = ov;
  assign rsp.payload = o;

  always_comb begin
    state_next  = state;
    armed_next  = armed;
    pend_next   = pend;
    pend_v_next = pend_v;
    tail_m      = head_m;
    tail_h      = head_h;
    push        = 1'b0;
    push_data   = pend;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          armed_next = 1'b0;
          pend_next  = '0;
          // sweeps take no slot, so any slot value runs them
          if (in_range || (req.payload.cmd == dta_pkg::CMD_EXEC) ||
              (req.payload.cmd == dta_pkg::CMD_EXIT)) begin
            pend_v_next = 1'b0;
            state_next  = S_RUN;
          end else begin
            pend_next.status = (req.payload.cmd == dta_pkg::CMD_ALLOC) ?
                               dta_pkg::ST_INVAL : dta_pkg::ST_BADF;
            pend_v_next = 1'b1;
            state_next  = S_FLUSH;
          end
        end
      end
      S_RUN: begin
        if (hit && !stall) begin
          armed_next = 1'b1;
          pend_next  = '0;
          if (!is_sweep) begin
            pend_v_next = 1'b1;
            state_next  = S_FLUSH;
          end
          unique case (cmd_r)
            dta_pkg::CMD_ALLOC: begin
              if (!head_m.valid) begin
                tail_m             = '{valid: 1'b1, cloexec: ce_r, is_dir: dir_r};
                tail_h             = hin_r;
                pend_next.slot_out = dta_pkg::SLOT_W'(pos);
              end else if (pos == POS_LAST) begin
                pend_next.status = dta_pkg::ST_FULL;
              end else begin
                pend_v_next = pend_v;
                pend_next   = pend;
                state_next  = S_RUN;
              end
            end
            dta_pkg::CMD_FREE, dta_pkg::CMD_GET: begin
              if (head_m.valid) begin
                pend_next.slot_out       = dta_pkg::SLOT_W'(pos);
                pend_next.handle_out     = dta_pkg::HANDLE_W'(head_h);
                pend_next.handle_present = 1'b1;
                if (cmd_r == dta_pkg::CMD_FREE) begin
                  tail_m = '0;
                end
              end else begin
                pend_next.status = dta_pkg::ST_BADF;
              end
            end
            dta_pkg::CMD_DUP: begin
              pend_next.slot_out = dta_pkg::SLOT_W'(pos);
              if (head_m.valid) begin
                pend_next.handle_out     = dta_pkg::HANDLE_W'(head_h);
                pend_next.handle_present = 1'b1;
              end
              tail_m = '{valid: 1'b1, cloexec: 1'b0, is_dir: dir_r};
              tail_h = hin_r;
            end
            dta_pkg::CMD_FGET, dta_pkg::CMD_FSET: begin
              if (head_m.valid) begin
                pend_next.slot_out = dta_pkg::SLOT_W'(pos);
                if (cmd_r == dta_pkg::CMD_FGET) begin
                  pend_next.flag_out = head_m.cloexec;
                end else begin
                  tail_m.cloexec = ce_r;
                end
              end else begin
                pend_next.status = dta_pkg::ST_BADF;
              end
            end
            dta_pkg::CMD_EXEC, dta_pkg::CMD_EXIT: begin
              if (close) begin
                tail_m = '0;
                if (pend_v) begin
                  push           = 1'b1;
                  push_data      = pend;
                  push_data.last = 1'b0;
                end
                pend_next.slot_out       = dta_pkg::SLOT_W'(pos);
                pend_next.handle_out     = dta_pkg::HANDLE_W'(head_h);
                pend_next.handle_present = 1'b1;
                pend_v_next              = 1'b1;
              end else begin
                pend_next = pend;
              end
              if (pos == POS_LAST) begin
                state_next = S_FLUSH;
              end
            end
          endcase
        end
      end
      S_FLUSH: begin
        if (push_ok) begin
          push           = 1'b1;
          push_data      = pend_v ? pend : '0;
          push_data.last = 1'b1;
          pend_v_next    = 1'b0;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      armed  <= 1'b0;
      pend_v <= 1'b0;
      ov     <= 1'b0;
      pos    <= '0;
    end else begin
      state  <= state_next;
      armed  <= armed_next;
      pend_v <= pend_v_next;
      if (push) begin
        ov <= 1'b1;
      end else if (rsp.ready) begin
        ov <= 1'b0;
      end
      if (rot) begin
        pos <= (pos == POS_LAST) ? '0 : PW'(pos + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (acc) begin
      cmd_r <= req.payload.cmd;
      start <= (req.payload.cmd == dta_pkg::CMD_EXEC || req.payload.cmd == dta_pkg::CMD_EXIT) ?
               '0 : PW'(req.payload.slot);
      ce_r  <= req.payload.cloexec;
      dir_r <= req.payload.is_dir;
      hin_r <= HANDLE_BITS'(req.payload.handle);
    end
    if (push) begin
      o <= push_data;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (!ov || rsp.ready))
    else $error("result pushed over a waiting transaction");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    acc |=> (state != S_IDLE))
    else $error("sequencer idle after accepting a command");

  a_rot_run: assert property (@(posedge clk) disable iff (rst)
    rot |-> (state == S_RUN))
    else $error("ring rotated outside a run");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_v)
    else $error("pending result left over in idle");

  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (rot && hit && is_sweep && pos == POS_LAST) |=> (state == S_FLUSH))
    else $error("sweep did not finish after a full turn");

endmodule

@@ src/dta_cell.sv @@
// One table entry; a stage of the rotating ring of entries.
module dta_cell #(
  parameter int HANDLE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   shift,
  input  dta_pkg::mark_t         mark_in,
  input  logic [HANDLE_BITS-1:0] handle_in,
  output dta_pkg::mark_t         mark,
  output logic [HANDLE_BITS-1:0] handle
);

  always_ff @(posedge clk) begin
    if (rst) begin
      mark <= '0;
    end else if (shift) begin
      mark <= mark_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      handle <= handle_in;
    end
  end

endmodule

@@ bench/dta_table_checker.sv @@
`timescale 1ns / 1ps
// Descriptor table checker: predicts results of each accepted command and compares them.
module dta_table_checker #(
  parameter int SLOTS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_ready,
  input  dta_pkg::req_t req_data,
  input  logic          rsp_valid,
  input  logic          rsp_ready,
  input  dta_pkg::rsp_t rsp_data,
  output int            fail_count,
  output int            awaiting,
  output int            results_checked,
  output int            entries_closed
);

  logic [dta_pkg::HANDLE_W-1:0] handle_tab [SLOTS];
  bit                           in_use     [SLOTS];
  bit                           exec_mark  [SLOTS];
  bit                           dir_mark   [SLOTS];

  dta_pkg::rsp_t expected_q [$];
  dta_pkg::rsp_t want;
  int   errors  = 0;
  int   checked = 0;
  int   closed  = 0;

  function automatic dta_pkg::rsp_t result_of(logic [1:0] st, int sl,
                                              logic [dta_pkg::HANDLE_W-1:0] h,
                                              logic hp, logic fl, logic lst);
    dta_pkg::rsp_t r;
    r.status         = st;
    r.slot_out       = dta_pkg::SLOT_W'(sl);
    r.handle_out     = h;
    r.handle_present = hp;
    r.flag_out       = fl;
    r.last           = lst;
    return r;
  endfunction

  task automatic predict_command(input dta_pkg::req_t r);
    int s;
    int closes [$];
    bit found;
    s     = int'(r.slot);
    found = 1'b0;
    case (r.cmd)
      dta_pkg::CMD_EXEC, dta_pkg::CMD_EXIT: begin
        for (int i = 0; i < SLOTS; i++)
          if (in_use[i] && (r.cmd == dta_pkg::CMD_EXIT || exec_mark[i] || dir_mark[i]))
            closes.push_back(i);
        if (closes.size() == 0)
          expected_q.push_back(result_of(dta_pkg::ST_OK, 0, '0, 1'b0, 1'b0, 1'b1));
        foreach (closes[k]) begin
          expected_q.push_back(result_of(dta_pkg::ST_OK, closes[k], handle_tab[closes[k]],
                                         1'b1, 1'b0, k == closes.size() - 1));
          in_use[closes[k]]    = 1'b0;
          exec_mark[closes[k]] = 1'b0;
          dir_mark[closes[k]]  = 1'b0;
        end
        closed += closes.size();
      end
      dta_pkg::CMD_ALLOC: begin
        if (s >= SLOTS) begin
          expected_q.push_back(result_of(dta_pkg::ST_INVAL, 0, '0, 1'b0, 1'b0, 1'b1));
        end else begin
          for (int i = s; i < SLOTS && !found; i++) begin
            if (!in_use[i]) begin
              handle_tab[i] = r.handle;
              in_use[i]     = 1'b1;
              exec_mark[i]  = r.cloexec;
              dir_mark[i]   = r.is_dir;
              found         = 1'b1;
              expected_q.push_back(result_of(dta_pkg::ST_OK, i, '0, 1'b0, 1'b0, 1'b1));
            end
          end
          if (!found)
            expected_q.push_back(result_of(dta_pkg::ST_FULL, 0, '0, 1'b0, 1'b0, 1'b1));
        end
      end
      default: begin
        if (s >= SLOTS) begin
          expected_q.push_back(result_of(dta_pkg::ST_BADF, 0, '0, 1'b0, 1'b0, 1'b1));
        end else if (r.cmd == dta_pkg::CMD_DUP) begin
          expected_q.push_back(result_of(dta_pkg::ST_OK, s, in_use[s] ? handle_tab[s] : '0,
                                         in_use[s], 1'b0, 1'b1));
          handle_tab[s] = r.handle;
          in_use[s]     = 1'b1;
          exec_mark[s]  = 1'b0;
          dir_mark[s]   = r.is_dir;
        end else if (!in_use[s]) begin
          expected_q.push_back(result_of(dta_pkg::ST_BADF, 0, '0, 1'b0, 1'b0, 1'b1));
        end else begin
          case (r.cmd)
            dta_pkg::CMD_FREE: begin
              expected_q.push_back(result_of(dta_pkg::ST_OK, s, handle_tab[s], 1'b1, 1'b0,
                                             1'b1));
              in_use[s]    = 1'b0;
              exec_mark[s] = 1'b0;
              dir_mark[s]  = 1'b0;
            end
            dta_pkg::CMD_GET:
              expected_q.push_back(result_of(dta_pkg::ST_OK, s, handle_tab[s], 1'b1, 1'b0,
                                             1'b1));
            dta_pkg::CMD_FGET:
              expected_q.push_back(result_of(dta_pkg::ST_OK, s, '0, 1'b0, exec_mark[s],
                                             1'b1));
            default: begin
              exec_mark[s] = r.cloexec;
              expected_q.push_back(result_of(dta_pkg::ST_OK, s, '0, 1'b0, 1'b0, 1'b1));
            end
          endcase
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        in_use[i]    = 1'b0;
        exec_mark[i] = 1'b0;
        dir_mark[i]  = 1'b0;
      end
      expected_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        checked++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display({"%0t: result with none pending: ",
                      "st=%0d slot=%0d h=%08h hp=%0b fl=%0b last=%0b"},
                     $realtime, rsp_data.status, rsp_data.slot_out, rsp_data.handle_out,
                     rsp_data.handle_present, rsp_data.flag_out, rsp_data.last);
        end else begin
          want = expected_q.pop_front();
          if (rsp_data !== want) begin
            errors++;
            if (errors <= 10) begin
              $display({"%0t: mismatch, expected ",
                        "st=%0d slot=%0d h=%08h hp=%0b fl=%0b last=%0b"},
                       $realtime, want.status, want.slot_out, want.handle_out,
                       want.handle_present, want.flag_out, want.last);
              $display({"%0t:           actual   ",
                        "st=%0d slot=%0d h=%08h hp=%0b fl=%0b last=%0b"},
                       $realtime, rsp_data.status, rsp_data.slot_out, rsp_data.handle_out,
                       rsp_data.handle_present, rsp_data.flag_out, rsp_data.last);
            end
          end
        end
      end
      if (req_valid && req_ready)
        predict_command(req_data);
    end
    fail_count      <= errors;
    awaiting        <= expected_q.size();
    results_checked <= checked;
    entries_closed  <= closed;
  end

endmodule

@@ bench/descriptor_table_allocator_top_test.sv @@
`timescale 1ns / 1ps
// Bench top: clock, reset, command stimulus with flow control, and the verdict.
module descriptor_table_allocator_top_test;

  localparam int SLOTS           = 64;
  localparam int ITEMS_PER_PHASE = 40;

  logic clk      = 1'b0;
  logic rst      = 1'b1;
  logic rsp_hold = 1'b0;
  bit   hold_req = 1'b0;
  int   src_idle_pct   = 0;
  int   sink_stall_pct = 0;
  int   sent = 0;
  int   fail_count;
  int   awaiting;
  int   results_checked;
  int   entries_closed;

  dta_chan_if #(.payload_t(dta_pkg::req_t)) req_ch ();
  dta_chan_if #(.payload_t(dta_pkg::rsp_t)) rsp_ch ();

  descriptor_table_allocator_top #(
    .SLOTS       (SLOTS),
    .HANDLE_BITS (dta_pkg::HANDLE_W)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  dta_table_checker #(
    .SLOTS (SLOTS)
  ) table_chk (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_ch.valid),
    .req_ready       (req_ch.ready),
    .req_data        (req_ch.payload),
    .rsp_valid       (rsp_ch.valid),
    .rsp_ready       (rsp_ch.ready),
    .rsp_data        (rsp_ch.payload),
    .fail_count      (fail_count),
    .awaiting        (awaiting),
    .results_checked (results_checked),
    .entries_closed  (entries_closed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    rsp_ch.ready <= !rsp_hold && ($urandom_range(99) >= sink_stall_pct);
  end

  // long result back-pressure so the table stalls its command input
  initial begin
    wait (hold_req);
    @(posedge clk);
    rsp_hold <= 1'b1;
    for (int n = 0; n < 160; n++)
      @(posedge clk);
    rsp_hold <= 1'b0;
  end

  initial begin
    #5_000_000;
    $display("descriptor_table_allocator_top verification failed");
    $finish;
  end

  function automatic dta_pkg::req_t mk(logic [2:0] c, int s,
                                       logic [dta_pkg::HANDLE_W-1:0] h, logic ce, logic d);
    dta_pkg::req_t r;
    r.cmd     = c;
    r.slot    = dta_pkg::SLOT_W'(s);
    r.handle  = h;
    r.cloexec = ce;
    r.is_dir  = d;
    return r;
  endfunction

  task automatic send(input dta_pkg::req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= r;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
  endtask

  initial begin
    dta_pkg::req_t r;
    int            pick;
    req_ch.valid   <= 1'b0;
    req_ch.payload <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, out-of-range slots, then a small populated table
    send(mk(dta_pkg::CMD_GET,    0, '0, 1'b0, 1'b0));
    send(mk(dta_pkg::CMD_FREE,   3, '0, 1'b0, 1'b0));
    send(mk(dta_pkg::CMD_FGET,   2, '0, 1'b0, 1'b0));
    send(mk(dta_pkg::CMD_FSET,   1, '0, 1'b1, 1'b0));
    send(mk(dta_pkg::CMD_EXEC,   0, '0, 1'b0, 1'b0));
    send(mk(dta_pkg::CMD_EXIT,   0, '0, 1'b0, 1'b0));
    send(mk(dta_pkg::CMD_ALLOC, 127, 32'h1111_1111, 1'b1, 1'b1));
    send(mk(dta_pkg::CMD_ALLOC,  64, 32'h2222_2222, 1'b0, 1'b0));
    send(mk(dta_pkg::CMD_FREE,   64, '0, 1'b0, 1'b0));
    send(mk(dta_pkg::CMD_DUP,   127, 32'h3333_3333, 1'b0, 1'b1));
    send(mk(dta_pkg::CMD_GET,   100, '0, 1'b0, 1'b0));
    send(mk(dta_pkg::CMD_ALLOC,   0, 32'hFFFF_FFFF, 1'b1, 1'b0));
    send(mk(dta_pkg::CMD_ALLOC,   0, 32'h0000_0000, 1'b0, 1'b1));
    send(mk(dta_pkg::CMD_ALLOC,   0, 32'h1234_5678, 1'b0, 1'b0));
    send(mk(dta_pkg::CMD_ALLOC,  63, 32'h8765_4321, 1'b0, 1'b0));
    send(mk(dta_pkg::CMD_ALLOC,  63, 32'hDEAD_BEEF, 1'b1, 1'b1));
    send(mk(dta_pkg::CMD_DUP,     2, 32'hA5A5_A5A5, 1'b1, 1'b1));
    send(mk(dta_pkg::CMD_DUP,     5, 32'h5A5A_5A5A, 1'b0, 1'b0));
    send(mk(dta_pkg::CMD_GET,     0, '0, 1'b0, 1'b0));
    send(mk(dta_pkg::CMD_FGET,    0, '0, 1'b0, 1'b0));
    send(mk(dta_pkg::CMD_FSET,    5, '0, 1'b1, 1'b0));
    send(mk(dta_pkg::CMD_FGET,    5, '0, 1'b0, 1'b0));
    send(mk(dta_pkg::CMD_FREE,   63, '0, 1'b0, 1'b0));
    send(mk(dta_pkg::CMD_EXEC,    0, '0, 1'b0, 1'b0));
    send(mk(dta_pkg::CMD_ALLOC,  10, 32'h0F0F_0F0F, 1'b0, 1'b0));
    send(mk(dta_pkg::CMD_EXIT,    0, '0, 1'b0, 1'b0));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
          hold_req       = 1'b1;
        end
        1: begin
          src_idle_pct   = 45;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 45;
        end
        default: begin
          src_idle_pct   = 15;
          sink_stall_pct = 15;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick      = $urandom_range(99);
        r.handle  = $urandom();
        r.cloexec = 1'($urandom_range(1));
        r.is_dir  = 1'($urandom_range(1));
        r.slot    = ($urandom_range(9) == 0) ? dta_pkg::SLOT_W'($urandom_range(63))
                                             : dta_pkg::SLOT_W'($urandom_range(15));
        if (pick < 30) begin
          r.cmd  = dta_pkg::CMD_ALLOC;
          r.slot = dta_pkg::SLOT_W'($urandom_range(7));
        end else if (pick < 45) begin
          r.cmd = dta_pkg::CMD_FREE;
        end else if (pick < 55) begin
          r.cmd = dta_pkg::CMD_DUP;
        end else if (pick < 65) begin
          r.cmd = dta_pkg::CMD_GET;
        end else if (pick < 73) begin
          r.cmd = dta_pkg::CMD_FGET;
        end else if (pick < 83) begin
          r.cmd = dta_pkg::CMD_FSET;
        end else if (pick < 88) begin
          r.cmd = dta_pkg::CMD_EXEC;
        end else if (pick < 90) begin
          r.cmd = dta_pkg::CMD_EXIT;
        end else begin
          // noise: any command, any slot including out of range
          r.cmd  = 3'($urandom_range(7));
          r.slot = dta_pkg::SLOT_W'($urandom_range(127));
        end
        send(r);
      end
    end

    // fill the upper region until it reports full, then close everything
    repeat (26)
      send(mk(dta_pkg::CMD_ALLOC, 40, $urandom(), 1'($urandom_range(1)),
              1'($urandom_range(1))));
    send(mk(dta_pkg::CMD_EXIT, 0, '0, 1'b0, 1'b0));
    req_ch.valid <= 1'b0;
    @(posedge clk);

    while (awaiting != 0)
      @(posedge clk);
    repeat (2 * SLOTS + 8) @(posedge clk);

    $display("Run covered %0d commands over four flow-control phases and one long result stall.",
             sent);
    $display("%0d results compared, %0d entries closed by exec and exit sweeps.",
             results_checked, entries_closed);
    if (fail_count == 0)
      $display("descriptor_table_allocator_top verification clean");
    else
      $display("descriptor_table_allocator_top verification failed");
    $finish;
  end

endmodule
